[rtl/tboh_pkg.sv]
// Shared types, constants and helpers for the threshold-binned occupancy histogram.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps

package tboh_pkg;

  // Storage geometry
  localparam int MAX_LAYERS     = 64;
  localparam int MAX_EDGES      = 32;
  localparam int COUNT_BITS     = 16;
  localparam int BINS_PER_LAYER = MAX_EDGES + 1;
  localparam int COUNT_DEPTH    = MAX_LAYERS * BINS_PER_LAYER;
  localparam int CNT_AW         = $clog2(COUNT_DEPTH);
  localparam int EDGE_AW        = $clog2(MAX_EDGES);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [CNT_AW-1:0]     CNT_LAST  = CNT_AW'(COUNT_DEPTH - 1);

  // Configuration register indexes and reset values
  localparam logic [1:0]  CFG_THRESHOLD = 2'd0;
  localparam logic [1:0]  CFG_BIN_COUNT = 2'd1;
  localparam logic [15:0] THRESHOLD_RST = 16'd128;
  localparam logic [4:0]  BIN_COUNT_RST = 5'd16;

  // Command codes
  typedef enum logic [1:0] {
    CMD_HIT       = 2'd0,
    CMD_READ      = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_LOAD_EDGE = 2'd3
  } cmd_t;

  // Channel payloads
  typedef struct packed {
    cmd_t               cmd;
    logic [15:0]        hit_energy;
    logic signed [15:0] hit_eta;
    logic [5:0]         layer_index;
    logic [5:0]         bin_select;
    logic [4:0]         edge_slot;
    logic signed [15:0] edge_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]            read_layer;
    logic [5:0]            read_bin;
    logic [COUNT_BITS-1:0] cell_count;
  } out_item_t;

  // Count store requests
  typedef enum logic [1:0] {
    CNT_NOP   = 2'd0,
    CNT_READ  = 2'd1,
    CNT_INCR  = 2'd2,
    CNT_CLEAR = 2'd3
  } cnt_op_t;

  typedef struct packed {
    cnt_op_t           op;
    logic [CNT_AW-1:0] addr;
  } cnt_req_t;

  typedef struct packed {
    logic                  busy;
    logic [COUNT_BITS-1:0] rdata;
  } cnt_rsp_t;

  // Bin search control
  typedef struct packed {
    logic               start;
    logic signed [15:0] x;
    logic [4:0]         n;
  } srch_req_t;

  typedef struct packed {
    logic       done;
    logic [5:0] bin;
  } srch_rsp_t;

  typedef struct packed {
    logic               en;
    logic [EDGE_AW-1:0] slot;
    logic signed [15:0] value;
  } edge_wr_t;

  // Flat cell address: layer * BINS_PER_LAYER + bin (constant multiply)
  function automatic logic [CNT_AW-1:0] cell_addr(input logic [5:0] layer,
                                                  input logic [5:0] bin);
    logic [CNT_AW-1:0] base;
    base = CNT_AW'(layer) * CNT_AW'(BINS_PER_LAYER);
    return base + CNT_AW'(bin);
  endfunction

endpackage

[rtl/threshold_binned_occupancy_histogram.sv]
// Top level: command sequencer, configuration registers and result register.
// Instantiates tboh_edge_search and tboh_count_store; depends on tboh_pkg.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_data  (in_item_t)
//   out     | output    | out_valid / out_stall| out_data (out_item_t)
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A hit above threshold stalls the in channel until it is done: a compare against
// the first edge, one against the last edge, then the bisection steps, each one
// registered edge-memory read, then a read and a write of the count memory.
// A read goes through a count-memory read to the result register (straight there with
// a zero count for a bin beyond overflow); a load edge or a hit at or below threshold
// leaves the sequencer idle. A clear, and the clearing pass after reset, sweep all
// 2112 count cells one a cycle; in_stall stays high meanwhile. Configuration writes
// are always taken. A waiting result in out_data holds while out_stall is high.
`timescale 1ns / 1ps

module threshold_binned_occupancy_histogram import tboh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SWAIT,
    S_INC,
    S_RD,
    S_RDW,
    S_OUT,
    S_CLR,
    S_WAIT
  } state_t;

  state_t                state;
  in_item_t              item;
  logic [15:0]           threshold;
  logic [4:0]            bin_count;
  logic [4:0]            n_bins;
  logic [CNT_AW-1:0]     addr;
  logic [COUNT_BITS-1:0] res_count;
  logic                  accept;
  srch_req_t             srch_req;
  srch_rsp_t             srch_rsp;
  edge_wr_t              edge_wr;
  cnt_req_t              cnt_req;
  cnt_rsp_t              cnt_rsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || cnt_rsp.busy;
  assign accept    = in_valid && !in_stall;
  assign n_bins    = (bin_count == 5'd0) ? 5'd1 : bin_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
      bin_count <= BIN_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_THRESHOLD) begin
        threshold <= cfg_data;
      end else if (cfg_index == CFG_BIN_COUNT) begin
        bin_count <= cfg_data[4:0];
      end
    end
  end

  // Edge loads go straight to the table on acceptance
  assign edge_wr.en    = accept && (in_data.cmd == CMD_LOAD_EDGE);
  assign edge_wr.slot  = in_data.edge_slot;
  assign edge_wr.value = in_data.edge_value;

  assign srch_req.start = state == S_SEARCH;
  assign srch_req.x     = item.hit_eta;
  assign srch_req.n     = n_bins;

  // Count store requests by state
  always_comb begin
    cnt_req.addr = addr;
    unique case (state)
      S_INC:   cnt_req.op = CNT_INCR;
      S_RD:    cnt_req.op = CNT_READ;
      S_CLR:   cnt_req.op = CNT_CLEAR;
      default: cnt_req.op = CNT_NOP;
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.cmd)
              CMD_HIT: begin
                if (in_data.hit_energy > threshold) begin
                  state <= S_SEARCH;
                end
              end
              CMD_READ: begin
                if (in_data.bin_select <= {1'b0, n_bins} + 6'd1) begin
                  state <= S_RD;
                end else begin
                  state <= S_OUT;
                end
              end
              CMD_CLEAR:     state <= S_CLR;
              CMD_LOAD_EDGE: state <= S_IDLE;
              default:       state <= S_IDLE;
            endcase
          end
        end
        S_SEARCH: state <= S_SWAIT;
        S_SWAIT: begin
          if (srch_rsp.done) begin
            state <= S_INC;
          end
        end
        S_INC:  state <= S_WAIT;
        S_RD:   state <= S_RDW;
        S_RDW:  state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_CLR:  state <= S_WAIT;
        S_WAIT: begin
          if (!cnt_rsp.busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end

    // Payload registers
    if (accept) begin
      item      <= in_data;
      addr      <= cell_addr(in_data.layer_index, in_data.bin_select);
      res_count <= '0;
    end
    if (state == S_SWAIT && srch_rsp.done) begin
      addr <= cell_addr(item.layer_index, srch_rsp.bin);
    end
    if (state == S_RDW) begin
      res_count <= cnt_rsp.rdata;
    end
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_data.read_layer <= item.layer_index;
      out_data.read_bin   <= item.bin_select;
      out_data.cell_count <= res_count;
    end
  end

  tboh_edge_search u_search (
    .clk     (clk),
    .rst     (rst),
    .edge_wr (edge_wr),
    .req     (srch_req),
    .rsp     (srch_rsp)
  );

  tboh_count_store u_counts (
    .clk (clk),
    .rst (rst),
    .req (cnt_req),
    .rsp (cnt_rsp)
  );

  // A search result arrives only while the sequencer waits for it
  a_search_done: assert property (@(posedge clk) disable iff (rst)
    srch_rsp.done |-> state == S_SWAIT)
    else $error("bin search finished outside its wait state");

  // Count requests are issued only to an idle count store
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    cnt_req.op != CNT_NOP |-> !cnt_rsp.busy)
    else $error("count request issued while count store busy");

  // A new result comes only from the output state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output state");

  // An accepted clear blocks the next transaction
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.cmd == CMD_CLEAR) |=> in_stall)
    else $error("transaction taken right after a clear");

endmodule

[rtl/tboh_edge_search.sv]
// Edge table and bisection unit: finds the eta bin of one hit by bisection over the edges.
// One registered edge-memory read and one signed compare per step. Depends on tboh_pkg.
`timescale 1ns / 1ps

module tboh_edge_search import tboh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  edge_wr_t  edge_wr,
  input  srch_req_t req,
  output srch_rsp_t rsp
);

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_FIRST,
    SR_LAST,
    SR_BISECT
  } sr_state_t;

  sr_state_t          state, state_next;
  logic signed [15:0] edge_mem [MAX_EDGES];
  logic signed [15:0] rdata;
  logic [4:0]         raddr;
  logic [4:0]         mid;
  logic [4:0]         lo, lo_next;
  logic [4:0]         hi, hi_next;
  logic [5:0]         span_sum;
  logic               lt;
  logic               fin;
  logic [5:0]         bin_next;

  // Shared comparator: hit eta against the edge just read
  assign lt       = req.x < rdata;
  assign span_sum = {1'b0, lo_next} + {1'b0, hi_next};

  // Step sequencing and next edge address
  always_comb begin
    state_next = state;
    raddr      = '0;
    lo_next    = lo;
    hi_next    = hi;
    fin        = 1'b0;
    bin_next   = rsp.bin;
    unique case (state)
      SR_IDLE: begin
        if (req.start) begin
          state_next = SR_FIRST;
        end
      end
      SR_FIRST: begin
        if (lt) begin
          fin        = 1'b1;
          bin_next   = '0;
          state_next = SR_IDLE;
        end else begin
          raddr      = req.n;
          state_next = SR_LAST;
        end
      end
      SR_LAST: begin
        lo_next = '0;
        hi_next = req.n;
        if (!lt) begin
          fin        = 1'b1;
          bin_next   = {1'b0, req.n} + 6'd1;
          state_next = SR_IDLE;
        end else if (req.n > 5'd1) begin
          raddr      = span_sum[5:1];
          state_next = SR_BISECT;
        end else begin
          fin        = 1'b1;
          bin_next   = 6'd1;
          state_next = SR_IDLE;
        end
      end
      SR_BISECT: begin
        if (!lt) begin
          lo_next = mid;
        end else begin
          hi_next = mid;
        end
        if (hi_next - lo_next > 5'd1) begin
          raddr = span_sum[5:1];
        end else begin
          fin        = 1'b1;
          bin_next   = {1'b0, lo_next} + 6'd1;
          state_next = SR_IDLE;
        end
      end
      default: state_next = SR_IDLE;
    endcase
  end

  // Hold state, bounds and the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SR_IDLE;
      rsp.done <= 1'b0;
    end else begin
      state    <= state_next;
      rsp.done <= fin;
    end
    lo      <= lo_next;
    hi      <= hi_next;
    mid     <= raddr;
    rsp.bin <= bin_next;
  end

  // Edge memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (edge_wr.en) begin
      edge_mem[edge_wr.slot] <= edge_wr.value;
    end
    rdata <= edge_mem[raddr];
  end

endmodule

[rtl/tboh_count_store.sv]
// Count memory with saturating read-modify-write, cell read and a clearing sweep.
// Sweeps the whole memory after reset and on a clear request. Depends on tboh_pkg.
`timescale 1ns / 1ps

module tboh_count_store import tboh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cnt_req_t req,
  output cnt_rsp_t rsp
);

  typedef enum logic [1:0] {
    C_CLEAR,
    C_IDLE,
    C_WRITE
  } c_state_t;

  c_state_t              state;
  logic [COUNT_BITS-1:0] mem [COUNT_DEPTH];
  logic [CNT_AW-1:0]     ptr;
  logic [CNT_AW-1:0]     addr_r;
  logic                  rd_en;
  logic                  mem_we;
  logic [CNT_AW-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] rdata;

  assign rsp.busy  = state != C_IDLE;
  assign rsp.rdata = rdata;
  assign rd_en     = (state == C_IDLE) && (req.op == CNT_READ || req.op == CNT_INCR);

  // Write side: zero during the sweep, saturated increment otherwise
  always_comb begin
    mem_we    = (state == C_CLEAR) || (state == C_WRITE);
    mem_waddr = (state == C_CLEAR) ? ptr : addr_r;
    if (state == C_CLEAR) begin
      mem_wdata = '0;
    end else if (rdata == COUNT_MAX) begin
      mem_wdata = rdata;
    end else begin
      mem_wdata = rdata + COUNT_BITS'(1);
    end
  end

  // Sequence sweep and read-modify-write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_CLEAR;
      ptr   <= '0;
    end else begin
      unique case (state)
        C_CLEAR: begin
          ptr <= ptr + CNT_AW'(1);
          if (ptr == CNT_LAST) begin
            state <= C_IDLE;
          end
        end
        C_IDLE: begin
          if (req.op == CNT_INCR) begin
            state <= C_WRITE;
          end else if (req.op == CNT_CLEAR) begin
            ptr   <= '0;
            state <= C_CLEAR;
          end
        end
        C_WRITE: state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
    if (rd_en) begin
      addr_r <= req.addr;
    end
  end

  // Memory array: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

[tb/sv/tboh_checker.sv]
// Read-result checker for the threshold-binned occupancy histogram.
// Watches the in, out and cfg channels, predicts every read; depends on tboh_pkg.
`timescale 1ns / 1ps

module tboh_checker import tboh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  // Predicted block state
  logic [15:0]           thresh_reg;
  logic [4:0]            bin_count_reg;
  logic signed [15:0]    edge_regs [MAX_EDGES];
  logic [COUNT_BITS-1:0] cell_counts [MAX_LAYERS][BINS_PER_LAYER];
  out_item_t             expected_reads [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Print one line per mismatch and count it
  task automatic note_mismatch(string what);
    $display("%0t ns mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Regular bins in use: zero raised to one, capped one below the edge table size
  function automatic int used_bins();
    int n;
    n = int'(bin_count_reg);
    if (n < 1) n = 1;
    if (n > MAX_EDGES - 1) n = MAX_EDGES - 1;
    return n;
  endfunction

  // Variable-bin axis lookup: underflow, overflow, else bisection
  function automatic int locate_eta_bin(logic signed [15:0] x, int n);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n;
    if (x < edge_regs[0]) return 0;
    if (x >= edge_regs[n]) return n + 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (edge_regs[mid] <= x) lo = mid;
      else hi = mid;
    end
    return lo + 1;
  endfunction

  task automatic clear_counts();
    for (int l = 0; l < MAX_LAYERS; l++) begin
      for (int b = 0; b < BINS_PER_LAYER; b++) begin
        cell_counts[l][b] = '0;
      end
    end
  endtask

  // Advance the prediction by one accepted command
  task automatic apply_command(in_item_t it);
    int n;
    int b;
    out_item_t rd;
    n = used_bins();
    case (it.cmd)
      CMD_HIT: begin
        if (it.hit_energy > thresh_reg && int'(it.layer_index) < MAX_LAYERS) begin
          b = locate_eta_bin(it.hit_eta, n);
          if (cell_counts[it.layer_index][b] != COUNT_MAX) begin
            cell_counts[it.layer_index][b] = cell_counts[it.layer_index][b] + 1'b1;
          end
        end
      end
      CMD_READ: begin
        rd.read_layer = it.layer_index;
        rd.read_bin   = it.bin_select;
        rd.cell_count = '0;
        if (int'(it.layer_index) < MAX_LAYERS && int'(it.bin_select) <= n + 1) begin
          rd.cell_count = cell_counts[it.layer_index][it.bin_select];
        end
        expected_reads.insert(expected_reads.size(), rd);
      end
      CMD_CLEAR: clear_counts();
      CMD_LOAD_EDGE: begin
        if (int'(it.edge_slot) < MAX_EDGES) edge_regs[it.edge_slot] = it.edge_value;
      end
      default: ;
    endcase
  endtask

  // Sample all three channels at the rising edge; results before new commands
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      thresh_reg    = THRESHOLD_RST;
      bin_count_reg = BIN_COUNT_RST;
      for (int e = 0; e < MAX_EDGES; e++) edge_regs[e] = '0;
      clear_counts();
      expected_reads.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          note_mismatch($sformatf("unexpected result layer %0d bin %0d count %0d",
                                  out_data.read_layer, out_data.read_bin,
                                  out_data.cell_count));
        end else begin
          want = expected_reads.pop_front();
          if (out_data.read_layer !== want.read_layer)
            note_mismatch($sformatf("read_layer got %0d want %0d",
                                    out_data.read_layer, want.read_layer));
          if (out_data.read_bin !== want.read_bin)
            note_mismatch($sformatf("read_bin got %0d want %0d (layer %0d)",
                                    out_data.read_bin, want.read_bin, want.read_layer));
          if (out_data.cell_count !== want.cell_count)
            note_mismatch($sformatf("cell_count got %0d want %0d (layer %0d bin %0d)",
                                    out_data.cell_count, want.cell_count,
                                    want.read_layer, want.read_bin));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD: thresh_reg    = cfg_data;
          CFG_BIN_COUNT: bin_count_reg = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) apply_command(in_data);
    end
    pending = expected_reads.size();
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the threshold-binned occupancy histogram: clock, reset, stimulus, verdict.
// Drives threshold_binned_occupancy_histogram and checks it through tboh_checker.
`timescale 1ns / 1ps

module tb import tboh_pkg::*; ();

  localparam int SETTLE_CYCLES = 2200;  // covers a full clear sweep
  localparam int HOLD_CYCLES   = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          reads_pending;

  // Stimulus shaping state
  int                 send_idle_pct = 12;
  int                 recv_idle_pct = 56;
  int                 hold_reqs = 0;
  int                 cur_n = 16;
  logic [15:0]        cur_thresh = THRESHOLD_RST;
  logic signed [15:0] edge_shadow [MAX_EDGES];

  always #5 clk = ~clk;

  threshold_binned_occupancy_histogram uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  tboh_checker hist_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (reads_pending)
  );

  // Receiver: random stall, or a long hold-off when one is requested
  initial begin : receiver
    int hold_seen;
    int stall_run;
    hold_seen = 0;
    stall_run = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        stall_run = HOLD_CYCLES;
      end
      if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Fill every field with noise, then set the command
  function automatic in_item_t random_item(cmd_t c);
    logic [95:0] raw;
    in_item_t    it;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.cmd = c;
    return it;
  endfunction

  function automatic logic [5:0] pick_layer();
    return ($urandom_range(9) < 7) ? 6'($urandom_range(3)) : 6'($urandom);
  endfunction

  function automatic logic [15:0] pick_energy();
    case ($urandom_range(3))
      0:       return cur_thresh;
      1:       return (cur_thresh == 16'hFFFF) ? cur_thresh : cur_thresh + 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one transaction after a random gap; return at the next falling edge
  task automatic send_item(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_hit(logic [15:0] energy, logic signed [15:0] eta, logic [5:0] layer);
    in_item_t it;
    it = random_item(CMD_HIT);
    it.hit_energy  = energy;
    it.hit_eta     = eta;
    it.layer_index = layer;
    send_item(it);
  endtask

  task automatic send_read(logic [5:0] layer, logic [5:0] bin);
    in_item_t it;
    it = random_item(CMD_READ);
    it.layer_index = layer;
    it.bin_select  = bin;
    send_item(it);
  endtask

  task automatic send_edge(logic [4:0] slot, logic signed [15:0] value);
    in_item_t it;
    it = random_item(CMD_LOAD_EDGE);
    it.edge_slot  = slot;
    it.edge_value = value;
    edge_shadow[slot] = value;
    send_item(it);
  endtask

  // Load edges 0..n ascending over most of the eta range, with jitter
  task automatic load_edge_ladder(int n);
    int step;
    int jit;
    step = 56000 / n;
    jit  = (step / 8 < 2000) ? step / 8 : 2000;
    for (int k = 0; k <= n; k++) begin
      send_edge(5'(k), 16'(-28000 + k * step + int'($urandom_range(jit))));
    end
  endtask

  // Drop valid and hold until every predicted read has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (reads_pending != 0);
  endtask

  // Drained and past the longest command, so a register write is safe
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random_item();
    int                 r;
    int                 k;
    logic signed [15:0] eta;
    r = $urandom_range(999);
    if (r < 550) begin
      case ($urandom_range(9))
        0, 1, 2, 3: eta = edge_shadow[$urandom_range(cur_n)];
        4:          eta = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        default:    eta = 16'($urandom);
      endcase
      send_hit(pick_energy(), eta, pick_layer());
    end else if (r < 880) begin
      send_read(pick_layer(), ($urandom_range(6) == 0) ? 6'($urandom)
                                                      : 6'($urandom_range(cur_n + 1)));
    end else if (r < 985) begin
      k = $urandom_range(MAX_EDGES - 1);
      if ($urandom_range(1)) send_edge(5'(k), edge_shadow[k]);
      else send_edge(5'(k), 16'($urandom));
    end else begin
      send_item(random_item(CMD_CLEAR));
    end
  endtask

  // Stimulus
  initial begin : stimulus
    int          items;
    logic [15:0] th;
    logic [4:0]  bc;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: edges first, so no hit ever reads an unloaded edge
    load_edge_ladder(MAX_EDGES - 1);
    send_hit(16'd129, 16'sh8000, 6'd0);                 // underflow
    send_hit(THRESHOLD_RST, 16'sh0000, 6'd0);           // equal to threshold: dropped
    send_hit(16'hFFFF, 16'sh7FFF, 6'd63);               // overflow, top layer
    send_hit(16'd200, edge_shadow[16], 6'd1);           // on the last edge: overflow
    send_hit(16'd200, edge_shadow[0], 6'd1);
    send_hit(16'd200, edge_shadow[5], 6'd1);
    send_hit(16'h0000, 16'sh0064, 6'd2);
    send_edge(5'd8, 16'sh8000);                         // break the ascending order
    send_hit(16'd1000, edge_shadow[9], 6'd2);
    send_edge(5'd8, 16'(-28000 + 8 * (56000 / (MAX_EDGES - 1))));
    send_read(6'd0, 6'd0);
    send_read(6'd63, 6'd17);
    send_read(6'd1, 6'd17);
    send_read(6'd1, 6'd1);
    send_read(6'd1, 6'd6);
    send_read(6'd2, 6'd9);
    send_read(6'd2, 6'd10);
    send_read(6'd5, 6'd63);                             // bin beyond overflow
    send_read(6'd1, 6'd18);
    send_item(random_item(CMD_CLEAR));
    send_read(6'd1, 6'd17);
    send_read(6'd63, 6'd17);

    // Random phases, each with its own register settings and idling mix
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin th = 16'($urandom_range(40000)); bc = 5'd31; items = 440; end
        1: begin th = 16'h0000; bc = 5'd0; items = 440;
                 send_idle_pct = 56; recv_idle_pct = 12; end
        2: begin th = 16'hFFFF; bc = 5'd1; items = 80;
                 send_idle_pct = 0; recv_idle_pct = 0; end
        default: begin th = 16'($urandom_range(1023)); bc = 5'($urandom_range(2, 30));
                       items = 370; end
      endcase
      write_reg(CFG_THRESHOLD, th);
      write_reg(CFG_BIN_COUNT, {11'd0, bc});
      cur_thresh = th;
      cur_n = (bc == 0) ? 1 : int'(bc);
      load_edge_ladder(cur_n);
      for (int k = 0; k < items; k++) begin
        if (p == 0 && k == 150) begin
          // Back up the block behind a held output, then let it drain
          hold_reqs++;
          repeat (30) send_read(pick_layer(), 6'($urandom_range(cur_n + 1)));
          wait_drained();
        end
        send_random_item();
      end
    end

    settle();
    if (fail_count == 0 && reads_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
rtl/tboh_pkg.sv
rtl/tboh_edge_search.sv
rtl/tboh_count_store.sv
rtl/threshold_binned_occupancy_histogram.sv
tb/sv/tboh_checker.sv
tb/sv/tb.sv
